// File: rtl/wth_pkg.sv
// ----------------------------------------------------------------------------
// wth_pkg
// Shared types and codes for the window table hit test block: request and
// status codes, the stored window entry and the query point.
// ----------------------------------------------------------------------------
package wth_pkg;

  // request codes
  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_HIT    = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

  // status codes
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_MISS = 2'd2;

  // one stored window
  typedef struct packed {
    logic [15:0] id;
    logic [15:0] left;
    logic [15:0] top;
    logic [15:0] wide;
    logic [15:0] tall;
    logic        shown;
  } entry_t;

  localparam int unsigned EntryBits = $bits(entry_t);

  // query point
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
  } point_t;

endpackage

// File: rtl/wth_ram.sv
// ----------------------------------------------------------------------------
// wth_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module wth_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/wth_hit.sv
// ----------------------------------------------------------------------------
// wth_hit
// Point-in-rectangle compare unit, shared by every step of a hit scan.
// Half-open bounds, right and bottom edges formed 18 bits wide so they
// never wrap.
// ----------------------------------------------------------------------------
module wth_hit (
  input  wth_pkg::entry_t entry_i,
  input  wth_pkg::point_t point_i,
  output logic            hit_o
);

  logic signed [17:0] left_s;
  logic signed [17:0] top_s;
  logic signed [17:0] right_s;
  logic signed [17:0] bottom_s;
  logic signed [17:0] px_s;
  logic signed [17:0] py_s;

  // sign-extend edges and point, widen the sums
  always_comb begin
    left_s   = 18'(signed'(entry_i.left));
    top_s    = 18'(signed'(entry_i.top));
    right_s  = left_s + signed'({2'b00, entry_i.wide});
    bottom_s = top_s + signed'({2'b00, entry_i.tall});
    px_s     = 18'(point_i.x);
    py_s     = 18'(point_i.y);
  end

  // visible and inside on both axes
  assign hit_o = entry_i.shown
                 && (px_s >= left_s) && (px_s < right_s)
                 && (py_s >= top_s) && (py_s < bottom_s);

endmodule

// File: rtl/window_table_hit_test.sv
// ----------------------------------------------------------------------------
// window_table_hit_test
// Ordered table of window rectangles with add, remove, clear and topmost
// point hit test, run by a small sequencer over one entry RAM.
// ----------------------------------------------------------------------------
// Sequence: add and clear go from accept straight to the result post step;
//   hit test and remove first scan the current entries through the RAM.
// Throughput: one request at a time; scan and shift steps share the single
//   RAM read port, and posting waits until the output register is free.
// Reset: entry count cleared, sequencer idle, no result pending; table
//   contents stay undefined and no clearing pass runs.
module window_table_hit_test #(
  parameter int unsigned MAX_WINDOWS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         req_type_i,
  input  logic [15:0]        win_id_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic [15:0]        rect_width_i,
  input  logic [15:0]        rect_height_i,
  input  logic               visible_in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic               hit_found_o,
  output logic [15:0]        hit_id_o,
  output logic [4:0]         entry_total_o
);

  localparam int unsigned AW = $clog2(MAX_WINDOWS);
  localparam int unsigned CW = $clog2(MAX_WINDOWS + 1);
  localparam logic [CW-1:0] MaxCount = CW'(MAX_WINDOWS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_HIT,
    ST_POST
  } state_e;

  state_e          state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic [15:0]     id_q, id_d;
  wth_pkg::point_t point_q, point_d;
  logic [1:0]      res_status_q, res_status_d;
  logic            res_found_q, res_found_d;
  logic [15:0]     res_id_q, res_id_d;
  logic            out_valid_q, out_valid_d;
  logic [1:0]      status_q, status_d;
  logic            found_q, found_d;
  logic [15:0]     hit_id_q, hit_id_d;
  logic [4:0]      total_q, total_d;

  logic            in_fire;
  wth_pkg::req_e   req;
  logic [CW-1:0]   idx_nxt;
  logic [CW-1:0]   idx_prv;
  logic [CW-1:0]   count_m1;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  wth_pkg::entry_t ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [wth_pkg::EntryBits-1:0] ram_rdata;
  wth_pkg::entry_t rd_entry;
  logic            hit;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign req        = wth_pkg::req_e'(req_type_i);
  assign idx_nxt    = idx_q + 1'b1;
  assign idx_prv    = idx_q - 1'b1;
  assign count_m1   = count_q - 1'b1;
  assign rd_entry   = wth_pkg::entry_t'(ram_rdata);

  // entry storage
  wth_ram #(
    .WIDTH (wth_pkg::EntryBits),
    .DEPTH (MAX_WINDOWS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // shared compare unit
  wth_hit u_hit (
    .entry_i (rd_entry),
    .point_i (point_q),
    .hit_o   (hit)
  );

  // sequencer next state
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    id_d         = id_q;
    point_d      = point_q;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    res_id_d     = res_id_q;
    out_valid_d  = out_valid_q;
    status_d     = status_q;
    found_d      = found_q;
    hit_id_d     = hit_id_q;
    total_d      = total_q;
    ram_we       = 1'b0;
    ram_waddr    = idx_prv[AW-1:0];
    ram_wdata    = rd_entry;
    ram_raddr    = idx_nxt[AW-1:0];

    // result beat taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        ram_raddr = (req == wth_pkg::REQ_REMOVE) ? '0 : count_m1[AW-1:0];
        if (in_fire) begin
          id_d         = win_id_i;
          point_d.x    = pos_x_i;
          point_d.y    = pos_y_i;
          res_status_d = wth_pkg::STAT_OK;
          res_found_d  = 1'b0;
          res_id_d     = '0;
          idx_d        = '0;
          state_d      = ST_POST;
          unique case (req)
            wth_pkg::REQ_ADD: begin
              if (count_q == MaxCount) begin
                res_status_d = wth_pkg::STAT_FULL;
              end else begin
                ram_we          = 1'b1;
                ram_waddr       = count_q[AW-1:0];
                ram_wdata.id    = win_id_i;
                ram_wdata.left  = pos_x_i;
                ram_wdata.top   = pos_y_i;
                ram_wdata.wide  = rect_width_i;
                ram_wdata.tall  = rect_height_i;
                ram_wdata.shown = visible_in_i;
                count_d         = count_q + 1'b1;
              end
            end
            wth_pkg::REQ_REMOVE: begin
              res_status_d = wth_pkg::STAT_MISS;
              if (count_q != '0) begin
                state_d = ST_SCAN;
              end
            end
            wth_pkg::REQ_HIT: begin
              res_status_d = wth_pkg::STAT_MISS;
              if (count_q != '0) begin
                idx_d   = count_m1;
                state_d = ST_HIT;
              end
            end
            wth_pkg::REQ_CLEAR: begin
              count_d = '0;
            end
            default: ;
          endcase
        end
      end

      // search oldest to newest for the id
      ST_SCAN: begin
        if (rd_entry.id == id_q) begin
          if (idx_nxt < count_q) begin
            idx_d   = idx_nxt;
            state_d = ST_SHIFT;
          end else begin
            count_d      = count_m1;
            res_status_d = wth_pkg::STAT_OK;
            state_d      = ST_POST;
          end
        end else if (idx_nxt == count_q) begin
          state_d = ST_POST;
        end else begin
          idx_d = idx_nxt;
        end
      end

      // move entry down one slot to close the gap
      ST_SHIFT: begin
        ram_we = 1'b1;
        if (idx_nxt < count_q) begin
          idx_d = idx_nxt;
        end else begin
          count_d      = count_m1;
          res_status_d = wth_pkg::STAT_OK;
          state_d      = ST_POST;
        end
      end

      // scan newest to oldest for a visible window holding the point
      ST_HIT: begin
        ram_raddr = idx_prv[AW-1:0];
        if (hit) begin
          res_status_d = wth_pkg::STAT_OK;
          res_found_d  = 1'b1;
          res_id_d     = rd_entry.id;
          state_d      = ST_POST;
        end else if (idx_q == '0) begin
          state_d = ST_POST;
        end else begin
          idx_d = idx_prv;
        end
      end

      // hand the result to the output register once it is free
      ST_POST: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          status_d    = res_status_q;
          found_d     = res_found_q;
          hit_id_d    = res_id_q;
          total_d     = 5'(count_q);
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      idx_q        <= '0;
      id_q         <= '0;
      point_q      <= '0;
      res_status_q <= wth_pkg::STAT_OK;
      res_found_q  <= 1'b0;
      res_id_q     <= '0;
      out_valid_q  <= 1'b0;
      status_q     <= wth_pkg::STAT_OK;
      found_q      <= 1'b0;
      hit_id_q     <= '0;
      total_q      <= '0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      idx_q        <= idx_d;
      id_q         <= id_d;
      point_q      <= point_d;
      res_status_q <= res_status_d;
      res_found_q  <= res_found_d;
      res_id_q     <= res_id_d;
      out_valid_q  <= out_valid_d;
      status_q     <= status_d;
      found_q      <= found_d;
      hit_id_q     <= hit_id_d;
      total_q      <= total_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign hit_found_o   = found_q;
  assign hit_id_o      = hit_id_q;
  assign entry_total_o = total_q;

  // table never holds more than its depth
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxCount)
    else $error("entry count above table depth");

  // clear empties the table
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && req == wth_pkg::REQ_CLEAR) |=> (count_q == '0))
    else $error("clear did not empty the table");

  // add into a table with room grows it by one
  a_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && req == wth_pkg::REQ_ADD && count_q < MaxCount)
      |=> (count_q == $past(count_q) + 1'b1))
    else $error("add did not grow the table");

  // ram writes only on an accepted add or during a shift
  a_write_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_SHIFT || (in_fire && req == wth_pkg::REQ_ADD)))
    else $error("unexpected table write");

  // a hit result always carries ok status
  a_hit_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && hit_found_o) |-> (status_o == wth_pkg::STAT_OK))
    else $error("hit reported with non-ok status");

endmodule

// File: verif/window_table_hit_test_checker.sv
// ----------------------------------------------------------------------------
// window_table_hit_test_checker
// Watches both handshake channels of the window table block. Every request
// beat updates a local copy of the window table and queues the reply it
// should produce; every reply beat is compared field by field against the
// oldest queued reply. Reports a mismatch count and the replies still due.
// ----------------------------------------------------------------------------
module window_table_hit_test_checker #(
  parameter int unsigned MAX_WINDOWS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [1:0]         req_type_i,
  input  logic [15:0]        win_id_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic [15:0]        rect_width_i,
  input  logic [15:0]        rect_height_i,
  input  logic               visible_in_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [1:0]         status_i,
  input  logic               hit_found_i,
  input  logic [15:0]        hit_id_i,
  input  logic [4:0]         entry_total_i,
  output int unsigned        mismatch_count_o,
  output int unsigned        replies_due_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // one reply beat
  typedef struct packed {
    logic [1:0]  status;
    logic        hit_found;
    logic [15:0] hit_id;
    logic [4:0]  entry_total;
  } reply_t;

  wth_pkg::entry_t win_table [MAX_WINDOWS];
  int unsigned     win_count;
  reply_t          expected_replies [$];
  int unsigned     mismatches;

  // half-open containment, edges summed at 32 bits so nothing wraps
  function automatic bit holds_point(wth_pkg::entry_t e, int px, int py);
    int l;
    int t;
    l = int'($signed(e.left));
    t = int'($signed(e.top));
    return (px >= l) && (px < l + int'(e.wide)) &&
           (py >= t) && (py < t + int'(e.tall));
  endfunction

  // update the window table for one request and return its reply
  function automatic reply_t apply_request(wth_pkg::req_e kind, logic [15:0] id,
                                           logic signed [15:0] x,
                                           logic signed [15:0] y,
                                           logic [15:0] w, logic [15:0] h,
                                           logic vis);
    reply_t r;
    int     k;
    int     j;
    r = '0;
    r.status = wth_pkg::STAT_OK;
    case (kind)
      wth_pkg::REQ_ADD: begin
        if (win_count >= MAX_WINDOWS) begin
          r.status = wth_pkg::STAT_FULL;
        end else begin
          win_table[win_count] = '{id: id, left: x, top: y, wide: w, tall: h,
                                   shown: vis};
          win_count++;
        end
      end
      wth_pkg::REQ_REMOVE: begin
        // oldest match goes, younger entries slide down
        r.status = wth_pkg::STAT_MISS;
        for (k = 0; k < int'(win_count); k++) begin
          if (win_table[k].id == id) begin
            for (j = k; j + 1 < int'(win_count); j++) begin
              win_table[j] = win_table[j + 1];
            end
            win_count--;
            r.status = wth_pkg::STAT_OK;
            break;
          end
        end
      end
      wth_pkg::REQ_HIT: begin
        // newest entry is on top
        r.status = wth_pkg::STAT_MISS;
        for (k = int'(win_count) - 1; k >= 0; k--) begin
          if (win_table[k].shown && holds_point(win_table[k], int'(x), int'(y))) begin
            r.status    = wth_pkg::STAT_OK;
            r.hit_found = 1'b1;
            r.hit_id    = win_table[k].id;
            break;
          end
        end
      end
      default: begin
        win_count = 0;
      end
    endcase
    r.entry_total = win_count[4:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, reply_t want, reply_t seen);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected status %0d found %0d id %h total %0d",
               $realtime, what, want.status, want.hit_found, want.hit_id,
               want.entry_total);
      $display("%0t: %s: actual   status %0d found %0d id %h total %0d",
               $realtime, what, seen.status, seen.hit_found, seen.hit_id,
               seen.entry_total);
    end
  endtask

  // reply beats are checked first, then the request beat of the same edge
  always @(posedge clk_i or negedge rst_ni) begin : watch
    reply_t seen;
    reply_t want;
    if (!rst_ni) begin
      win_count = 0;
      mismatches = 0;
      expected_replies.delete();
      replies_due_o <= 0;
      mismatch_count_o <= 0;
    end else begin
      // reply beat
      if (out_valid_i && out_ready_i) begin
        seen = '{status_i, hit_found_i, hit_id_i, entry_total_i};
        if (expected_replies.size() == 0) begin
          report_mismatch("reply with no request pending", '0, seen);
        end else begin
          want = expected_replies.pop_front();
          if (seen !== want) begin
            report_mismatch("reply differs", want, seen);
          end
        end
      end
      // request beat
      if (in_valid_i && in_ready_i) begin
        expected_replies.push_back(apply_request(wth_pkg::req_e'(req_type_i),
                                                 win_id_i, pos_x_i, pos_y_i,
                                                 rect_width_i, rect_height_i,
                                                 visible_in_i));
      end
      replies_due_o <= expected_replies.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the window table hit test block with a short directed sequence
// (boundaries, hidden and empty windows, duplicate ids, misses, clears) and
// then about two thousand random requests in add-heavy and scan-heavy
// phases, with bursty requests and a stalling reply side. The checker beside
// the block predicts and compares every reply.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumWindows  = 16;
  localparam int unsigned RandomItems = 2000;
  localparam int unsigned CycleLimit  = 2_500_000;

  // reply side stall patterns
  typedef enum int unsigned {
    SINK_OPEN,
    SINK_COIN,
    SINK_SPARSE,
    SINK_DENSE
  } sink_mode_e;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               in_valid_i    = 1'b0;
  logic               in_ready_o;
  logic [1:0]         req_type_i    = '0;
  logic [15:0]        win_id_i      = '0;
  logic signed [15:0] pos_x_i       = '0;
  logic signed [15:0] pos_y_i       = '0;
  logic [15:0]        rect_width_i  = '0;
  logic [15:0]        rect_height_i = '0;
  logic               visible_in_i  = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i   = 1'b0;
  logic [1:0]         status_o;
  logic               hit_found_o;
  logic [15:0]        hit_id_o;
  logic [4:0]         entry_total_o;

  int unsigned mismatch_count;
  int unsigned replies_due;
  int unsigned cycle_count = 0;
  int unsigned burst_left  = 0;

  window_table_hit_test #(
    .MAX_WINDOWS(NumWindows)
  ) u_top (.*);

  window_table_hit_test_checker #(
    .MAX_WINDOWS(NumWindows)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .req_type_i      (req_type_i),
    .win_id_i        (win_id_i),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .rect_width_i    (rect_width_i),
    .rect_height_i   (rect_height_i),
    .visible_in_i    (visible_in_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_i        (status_o),
    .hit_found_i     (hit_found_o),
    .hit_id_i        (hit_id_o),
    .entry_total_i   (entry_total_o),
    .mismatch_count_o(mismatch_count),
    .replies_due_o   (replies_due)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // one request beat; a gap of random length opens each new burst
  task automatic send_request(wth_pkg::req_e kind, logic [15:0] id,
                              logic signed [15:0] x, logic signed [15:0] y,
                              logic [15:0] w, logic [15:0] h, logic vis);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                : $urandom_range(1, 12);
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= kind;
    win_id_i      <= id;
    pos_x_i       <= x;
    pos_y_i       <= y;
    rect_width_i  <= w;
    rect_height_i <= h;
    visible_in_i  <= vis;
    do @(posedge clk_i); while (!in_ready_o);
    burst_left--;
  endtask

  // stop offering until every reply has come back
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (replies_due != 0) @(posedge clk_i);
  endtask

  // mostly near the origin so rectangles overlap, now and then anywhere
  function automatic logic signed [15:0] pick_coord();
    if ($urandom_range(0, 99) < 85) begin
      return 16'(int'($urandom_range(0, 100)) - 40);
    end
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_size();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      return '0;
    end else if (roll < 85) begin
      return 16'($urandom_range(1, 40));
    end
    return 16'($urandom);
  endfunction

  // random request; the phase shifts the mix between filling and scanning
  task automatic send_random(int unsigned phase);
    int unsigned   roll;
    int unsigned   add_pct;
    wth_pkg::req_e kind;
    logic [15:0]   id;
    add_pct = (phase % 3 == 0) ? 65 : ((phase % 3 == 1) ? 40 : 25);
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      kind = wth_pkg::REQ_CLEAR;
    end else if (roll < 2 + add_pct) begin
      kind = wth_pkg::REQ_ADD;
    end else if (roll < 2 + add_pct + (98 - add_pct) / 3) begin
      kind = wth_pkg::REQ_REMOVE;
    end else begin
      kind = wth_pkg::REQ_HIT;
    end
    id = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, 11)) : 16'($urandom);
    send_request(kind, id, pick_coord(), pick_coord(), pick_size(), pick_size(),
                 $urandom_range(0, 3) != 0);
  endtask

  // reply side: stall patterns, plus long hold-offs that back up the block
  initial begin : reply_sink
    sink_mode_e mode;
    int unsigned span;
    bit held_once;
    held_once = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      mode = sink_mode_e'($urandom_range(0, 3));
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(posedge clk_i);
        case (mode)
          SINK_OPEN:   out_ready_i <= 1'b1;
          SINK_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
          SINK_SPARSE: out_ready_i <= ($urandom_range(0, 3) == 0);
          default:     out_ready_i <= ($urandom_range(0, 3) != 0);
        endcase
      end
      if (!held_once || $urandom_range(0, 9) == 0) begin
        held_once = 1'b1;
        @(posedge clk_i);
        out_ready_i <= 1'b0;
        repeat ($urandom_range(150, 250)) @(posedge clk_i);
      end
    end
  end

  // stimulus and verdict
  initial begin : stimulus
    int unsigned n;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table: clear, miss, unknown id
    send_request(wth_pkg::REQ_CLEAR, 16'h0000, 16'sh0000, 16'sh0000,
                 16'h0000, 16'h0000, 1'b0);
    send_request(wth_pkg::REQ_HIT, 16'hFFFF, 16'sh0000, 16'sh0000,
                 16'hFFFF, 16'hFFFF, 1'b1);
    send_request(wth_pkg::REQ_REMOVE, 16'h0005, 16'sh0000, 16'sh0000,
                 16'h0000, 16'h0000, 1'b0);
    // widest window from the most negative corner
    send_request(wth_pkg::REQ_ADD, 16'hFFFF, 16'sh8000, 16'sh8000,
                 16'hFFFF, 16'hFFFF, 1'b1);
    send_request(wth_pkg::REQ_HIT, 16'h0000, 16'sh8000, 16'sh8000,
                 16'h0000, 16'h0000, 1'b0);
    send_request(wth_pkg::REQ_HIT, 16'h0000, 16'sh7FFF, 16'sh7FFF,
                 16'h0000, 16'h0000, 1'b0);
    // far edge plus full size must not wrap
    send_request(wth_pkg::REQ_ADD, 16'h0000, 16'sh7FFF, 16'sh7FFF,
                 16'hFFFF, 16'hFFFF, 1'b1);
    send_request(wth_pkg::REQ_HIT, 16'h0000, 16'sh7FFF, 16'sh7FFF,
                 16'h0000, 16'h0000, 1'b0);
    // hidden window on top, then a visible duplicate id
    send_request(wth_pkg::REQ_ADD, 16'h1234, 16'sd10, 16'sd20,
                 16'd5, 16'd7, 1'b0);
    send_request(wth_pkg::REQ_HIT, 16'h0000, 16'sd10, 16'sd20,
                 16'h0000, 16'h0000, 1'b0);
    send_request(wth_pkg::REQ_ADD, 16'h1234, 16'sd10, 16'sd20,
                 16'd5, 16'd7, 1'b1);
    send_request(wth_pkg::REQ_HIT, 16'h0000, 16'sd14, 16'sd26,
                 16'h0000, 16'h0000, 1'b0);
    send_request(wth_pkg::REQ_HIT, 16'h0000, 16'sd15, 16'sd20,
                 16'h0000, 16'h0000, 1'b0);
    send_request(wth_pkg::REQ_HIT, 16'h0000, 16'sd10, 16'sd27,
                 16'h0000, 16'h0000, 1'b0);
    // zero width holds nothing
    send_request(wth_pkg::REQ_ADD, 16'h0007, 16'sd0, 16'sd0,
                 16'd0, 16'd100, 1'b1);
    send_request(wth_pkg::REQ_HIT, 16'h0000, 16'sd0, 16'sd0,
                 16'h0000, 16'h0000, 1'b0);
    // duplicate id: only the oldest goes
    send_request(wth_pkg::REQ_REMOVE, 16'h1234, 16'sh7FFF, 16'sh8000,
                 16'hFFFF, 16'hFFFF, 1'b1);
    send_request(wth_pkg::REQ_HIT, 16'h0000, 16'sd10, 16'sd20,
                 16'h0000, 16'h0000, 1'b0);
    send_request(wth_pkg::REQ_REMOVE, 16'h9999, 16'sh0000, 16'sh0000,
                 16'h0000, 16'h0000, 1'b0);
    send_request(wth_pkg::REQ_CLEAR, 16'hFFFF, 16'shFFFF, 16'shFFFF,
                 16'hFFFF, 16'hFFFF, 1'b1);
    send_request(wth_pkg::REQ_HIT, 16'h0000, 16'sd0, 16'sd0,
                 16'h0000, 16'h0000, 1'b0);
    wait_for_drain();

    // random phases, with one full pause halfway
    for (n = 0; n < RandomItems; n++) begin
      if (n == RandomItems / 2) begin
        wait_for_drain();
      end
      send_random(n / 150);
    end
    wait_for_drain();
    repeat (40) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
